// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define MBR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked at every edge, reset included.
`define MBR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/mbr_pkg.sv -----
// Types and constants for the masked background replace unit.
package mbr_pkg;

    localparam int unsigned PIX_CH = 3;

    localparam logic [7:0]  GREY_LEVEL  = 8'd127;
    localparam logic [7:0]  MASK_PASS   = 8'h00;
    localparam logic [7:0]  MASK_FREEZE = 8'hFF;
    localparam logic [16:0] ALPHA_ONE   = 17'h10000;
    localparam logic [16:0] ALPHA_RESET = 17'd3277;

    typedef struct packed {
        logic [7:0] pixel_ch0;
        logic [7:0] pixel_ch1;
        logic [7:0] pixel_ch2;
        logic [7:0] human_mask;
        logic       frame_end;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_ch0;
        logic [7:0] out_ch1;
        logic [7:0] out_ch2;
        logic       out_last;
    } t_pix_out;

endpackage

// ----- design/mbr_if.sv -----
// Valid/ready stream interfaces for the pixel input and output channels.
interface mbr_in_if
    import mbr_pkg::*;
();
    logic    valid;
    logic    ready;
    t_pix_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mbr_out_if
    import mbr_pkg::*;
();
    logic     valid;
    logic     ready;
    t_pix_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/masked_background_replace_unit.sv -----
// Masked background replace unit: running-average background model with masked output.
//
// Pixels arrive in raster order, one item per pixel with its mask byte, and the unit
// sustains one item per clock while the sink is ready. Each item reads its background
// entry from a single synchronous memory when accepted, blends and writes it back when
// it leaves stage 1, and lands in an output register. The result is offered from that
// register and is taken when the sink is ready. At most two items are in flight, so
// a stalled sink blocks the input after two items. The read-modify-write loop on
// the memory sets the rate. A frame of one pixel, where the write and the next
// read hit the same entry, is served by a forwarding register.
// The background reads as 127 in every channel until the first frame_end (or address
// wrap at MAX_PIXELS) has passed; there is no clearing pass after reset.
// Blend: bg' = round_half_even(bg + (pix - bg) * alpha / 65536), with alpha equal to
// learning_rate saturated to 65536. Mask 255 freezes the entry, mask 0 passes the
// pixel through, any other mask outputs the updated background. Write learning_rate
// only while the unit is idle.
module masked_background_replace_unit
    import mbr_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = 524288,
    parameter int unsigned CHANNELS   = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mbr_in_if.sink        i_pix,
    mbr_out_if.source     o_pix,
    input  logic          i_cfg_we,
    input  logic [16:0]   i_cfg_wdata
);

    localparam int unsigned NCH = (CHANNELS < PIX_CH) ? CHANNELS : PIX_CH;
    localparam int unsigned MW  = NCH * 8;
    localparam int unsigned AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);

    // blend with round-half-even and saturation; one signed multiply
    function automatic logic [7:0] blend(input logic [7:0] bg, input logic [7:0] pix,
                                         input logic [16:0] a);
        logic signed [8:0]  d;
        logic signed [25:0] prod;
        logic [25:0]        s;
        logic [9:0]         q;
        logic [15:0]        r;
        logic [10:0]        qr;
        d    = $signed({1'b0, pix}) - $signed({1'b0, bg});
        prod = 26'(d) * 26'($signed({1'b0, a}));
        s    = {2'b00, bg, 16'h0000} + $unsigned(prod);
        q    = s[25:16];
        r    = s[15:0];
        qr   = {1'b0, q} + (((r > 16'h8000) || ((r == 16'h8000) && q[0])) ? 11'd1 : 11'd0);
        blend = (qr > 11'd255) ? 8'hFF : qr[7:0];
    endfunction

    // control state
    logic [16:0]   r_lrate;
    logic [AW-1:0] r_addr;
    logic          r_bg_ready;
    logic          r_s1_v;
    logic          r_o_v;

    // stage 1 payload
    t_pix_in       r_s1_pix;
    logic [AW-1:0] r_s1_addr;
    logic          r_s1_rdy;
    logic          r_fwd;
    logic [MW-1:0] r_fwd_data;
    logic [MW-1:0] r_bg_q;
    t_pix_out      r_o_data;

    // background store
    logic [MW-1:0] r_bg_mem [MAX_PIXELS];

    logic          in_acc;
    logic          s1_adv;
    logic [16:0]   alpha;
    logic [MW-1:0] bg_word;
    logic [MW-1:0] s1_wdata;
    logic [7:0]    s1_pix [PIX_CH];
    logic [7:0]    s1_out [PIX_CH];
    t_pix_out      n_o_data;

    assign s1_adv = r_s1_v && (!r_o_v || o_pix.ready);
    assign i_pix.ready = !r_s1_v || s1_adv;
    assign in_acc = i_pix.valid && i_pix.ready;

    assign alpha = (r_lrate > ALPHA_ONE) ? ALPHA_ONE : r_lrate;

    // grey until the first frame is in, forwarded word when the previous item
    // wrote this entry in the cycle of the read
    always_comb begin
        if (!r_s1_rdy) begin
            bg_word = {NCH{GREY_LEVEL}};
        end else if (r_fwd) begin
            bg_word = r_fwd_data;
        end else begin
            bg_word = r_bg_q;
        end
    end

    assign s1_pix[0] = r_s1_pix.pixel_ch0;
    assign s1_pix[1] = r_s1_pix.pixel_ch1;
    assign s1_pix[2] = r_s1_pix.pixel_ch2;

    for (genvar c = 0; c < PIX_CH; c++) begin : g_ch
        if (c < NCH) begin : g_used
            logic [7:0] bg;
            logic [7:0] nbg;
            assign bg  = bg_word[c*8 +: 8];
            assign nbg = (r_s1_pix.human_mask != MASK_FREEZE) ?
                         blend(bg, s1_pix[c], alpha) : bg;
            assign s1_wdata[c*8 +: 8] = nbg;
            assign s1_out[c] = (r_s1_pix.human_mask != MASK_PASS) ? nbg : s1_pix[c];
        end else begin : g_unused
            assign s1_out[c] = 8'h00;
        end
    end

    always_comb begin
        n_o_data.out_ch0  = s1_out[0];
        n_o_data.out_ch1  = s1_out[1];
        n_o_data.out_ch2  = s1_out[2];
        n_o_data.out_last = r_s1_pix.frame_end;
    end

    // memory: read on accept, write back when stage 1 moves on
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_bg_mem[r_s1_addr] <= s1_wdata;
        end
        if (in_acc) begin
            r_bg_q <= r_bg_mem[r_addr];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lrate    <= ALPHA_RESET;
            r_addr     <= '0;
            r_bg_ready <= 1'b0;
            r_s1_v     <= 1'b0;
            r_o_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lrate <= i_cfg_wdata;
            end
            if (in_acc) begin
                if (i_pix.data.frame_end || (r_addr == LAST_ADDR)) begin
                    r_addr     <= '0;
                    r_bg_ready <= 1'b1;
                end else begin
                    r_addr <= r_addr + AW'(1);
                end
            end
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_o_v <= 1'b1;
            end else if (o_pix.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix   <= i_pix.data;
            r_s1_addr  <= r_addr;
            r_s1_rdy   <= r_bg_ready;
            r_fwd      <= s1_adv && (r_s1_addr == r_addr);
            r_fwd_data <= s1_wdata;
        end
        if (s1_adv) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_pix.valid = r_o_v;
    assign o_pix.data  = r_o_data;

endmodule

// ----- design/mbr_checker.sv -----
// Port-level checker for the masked background replace unit, with its bind.
`include "assert_macros.svh"

module mbr_checker
    import mbr_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     i_in_ready,
    input logic     i_out_valid,
    input logic     i_out_ready,
    input t_pix_out i_out_data
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_cnt;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    `MBR_ASSERT_ALWAYS(a_reset_no_out, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")
    `MBR_ASSERT(a_no_invented, i_clk, i_rst_n, (r_cnt == 2'd0) |-> !i_out_valid, "item without input")
    `MBR_ASSERT(a_depth, i_clk, i_rst_n, r_cnt != 2'd3, "more than two items in flight")
    `MBR_ASSERT(a_ready_empty, i_clk, i_rst_n, (r_cnt == 2'd0) |-> i_in_ready, "stalled while empty")
    `MBR_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)), "stalled output changed")

endmodule

bind masked_background_replace_unit mbr_checker u_mbr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_data  (o_pix.data)
);
